// ===== design/mbe_pkg.sv =====
`timescale 1ns / 1ps

package mbe_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 28;
  localparam int COUNT_WIDTH = 10;

  // product width, and sum width with two extra bits
  localparam int PROD_WIDTH = 2 * COORD_WIDTH;
  localparam int SUM_WIDTH  = PROD_WIDTH + 2;

  localparam logic [COUNT_WIDTH-1:0] MAX_ITER_RESET = COUNT_WIDTH'(50);

  // register indexes
  localparam logic REG_MAX_ITER = 1'b0;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] c_real;
    logic signed [COORD_WIDTH-1:0] c_imag;
  } in_word_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] escape_count;
    logic                   in_set;
  } out_word_t;

  typedef struct packed {
    logic start;     // load c, z = c, counter = limit
    logic mul;       // register the three products
    logic step;      // z = z*z + c, counter - 1
    logic load_out;  // capture result into output register
  } dp_cmd_t;

  typedef struct packed {
    logic escaped;
    logic left_zero;
  } dp_status_t;

  // clamp a wide signed value to the coordinate range
  function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
      input logic signed [SUM_WIDTH-1:0] v);
    logic [SUM_WIDTH-COORD_WIDTH:0] top;
    logic signed [COORD_WIDTH-1:0] r;
    top = v[SUM_WIDTH-1:COORD_WIDTH-1];
    if ((&top) || !(|top)) begin
      r = v[COORD_WIDTH-1:0];
    end else if (v[SUM_WIDTH-1]) begin
      r = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== design/mbe_datapath.sv =====
`timescale 1ns / 1ps

module mbe_datapath (
  input  logic                            clk_i,
  input  mbe_pkg::in_word_t               in_word_i,
  input  logic [mbe_pkg::COUNT_WIDTH-1:0] max_iter_i,
  input  mbe_pkg::dp_cmd_t                cmd_i,
  output mbe_pkg::dp_status_t             status_o,
  output mbe_pkg::out_word_t              out_word_o
);
  import mbe_pkg::*;

  localparam logic signed [SUM_WIDTH-1:0] THRESH =
    SUM_WIDTH'(1) << (2 * FRAC_BITS + 2);

  logic signed [COORD_WIDTH-1:0] x_q, x_d, y_q, y_d, cr_q, ci_q;
  logic signed [PROD_WIDTH-1:0]  xx_q, yy_q, xy_q;
  logic [COUNT_WIDTH-1:0]        left_q, left_d;
  out_word_t                     out_q, out_d;

  logic signed [SUM_WIDTH-1:0] mag, re_raw, re_sh, re_sum, im_raw, im_sh, im_sum;

  always_comb begin
    // |z|^2 exact at product precision
    mag    = {{2{xx_q[PROD_WIDTH-1]}}, xx_q} + {{2{yy_q[PROD_WIDTH-1]}}, yy_q};
    re_raw = {{2{xx_q[PROD_WIDTH-1]}}, xx_q} - {{2{yy_q[PROD_WIDTH-1]}}, yy_q};
    im_raw = {xy_q[PROD_WIDTH-1], xy_q, 1'b0};
    re_sh  = re_raw >>> FRAC_BITS;
    im_sh  = im_raw >>> FRAC_BITS;
    re_sum = re_sh + {{(SUM_WIDTH-COORD_WIDTH){cr_q[COORD_WIDTH-1]}}, cr_q};
    im_sum = im_sh + {{(SUM_WIDTH-COORD_WIDTH){ci_q[COORD_WIDTH-1]}}, ci_q};
  end

  assign status_o.escaped   = mag > THRESH;
  assign status_o.left_zero = (left_q == '0);

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    left_d = left_q;
    if (cmd_i.start) begin
      x_d    = in_word_i.c_real;
      y_d    = in_word_i.c_imag;
      left_d = max_iter_i;
    end else if (cmd_i.step) begin
      x_d    = sat_coord(re_sum);
      y_d    = sat_coord(im_sum);
      left_d = left_q - COUNT_WIDTH'(1);
    end
  end

  always_comb begin
    out_d              = out_q;
    if (cmd_i.load_out) begin
      out_d.escape_count = status_o.escaped ? left_q : '0;
      out_d.in_set       = !status_o.escaped;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    left_q <= left_d;
    out_q  <= out_d;
    if (cmd_i.start) begin
      cr_q <= in_word_i.c_real;
      ci_q <= in_word_i.c_imag;
    end
    if (cmd_i.mul) begin
      xx_q <= x_q * x_q;
      yy_q <= y_q * y_q;
      xy_q <= x_q * y_q;
    end
  end

  assign out_word_o = out_q;

endmodule

// ===== design/mbe_ctrl.sv =====
`timescale 1ns / 1ps

module mbe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  mbe_pkg::dp_status_t status_i,
  output mbe_pkg::dp_cmd_t    cmd_o
);
  import mbe_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_EVAL = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       finish, out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);
  assign finish     = status_i.escaped || status_i.left_zero;

  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    cmd_o        = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_EVAL;
      end
      ST_EVAL, ST_HOLD: begin
        if (state_q == ST_EVAL && !finish) begin
          cmd_o.step = 1'b1;
          state_d    = ST_MUL;
        end else if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          state_d = ST_HOLD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== design/mandelbrot_escape_time.sv =====
`timescale 1ns / 1ps

// Mandelbrot escape-time engine. Each input word is a point c (signed Q4.28);
// z starts at c and is iterated z = z*z + c until |z|^2 > 4 or the limit N in
// max_iterations (APB register at address 0, reset 50) runs out. The result
// word gives the remaining count N - updates on escape, or in_set = 1 with
// count 0 for a point that never escapes. One point is in flight at a time;
// each round is a product register step, then the escape test and update,
// and a point runs from 1 to N+1 rounds. The finished result sits in an
// output register, so the next point is taken while the result waits; a
// point that finishes while that register is still full is held until it
// frees.

module mandelbrot_escape_time (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input words
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mbe_pkg::in_word_t  in_word_i,
  // result words
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mbe_pkg::out_word_t out_word_o,
  // APB configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import mbe_pkg::*;

  logic [COUNT_WIDTH-1:0] max_iter_q, max_iter_d;
  logic                   reg_index;
  dp_cmd_t                cmd;
  dp_status_t             status;

  // register file: byte address 4*i, low address bits ignored
  assign pready    = 1'b1;
  assign reg_index = paddr[2];

  always_comb begin
    max_iter_d = max_iter_q;
    if (psel && penable && pwrite && reg_index == REG_MAX_ITER) begin
      max_iter_d = pwdata[COUNT_WIDTH-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_index == REG_MAX_ITER) begin
      prdata = 32'(max_iter_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= MAX_ITER_RESET;
    end else begin
      max_iter_q <= max_iter_d;
    end
  end

  // sequencer: accept, multiply, evaluate, hand off result
  mbe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // iterate registers, products, counter and output register
  mbe_datapath u_datapath (
    .clk_i      (clk_i),
    .in_word_i  (in_word_i),
    .max_iter_i (max_iter_q),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_word_o (out_word_o)
  );

endmodule

// ===== tb/tb_mandelbrot_escape_time.sv =====
`timescale 1ns / 1ps

module tb_mandelbrot_escape_time;
  import mbe_pkg::*;

  // Q4.28 handy values
  localparam int ONE = 1 << FRAC_BITS;
  localparam int TWO = 2 * ONE;

  // tail wait sized to cover the slowest point, N up to 1023
  localparam int TAIL_CYCLES = 2 * (1 << COUNT_WIDTH) + 8;
  localparam int LONG_HOLD   = 400;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  // stimulus side
  logic      in_valid  = 1'b0;
  in_word_t  in_word   = '0;
  logic      in_ready_o;

  // result side
  logic      out_valid_o;
  logic      out_ready = 1'b0;
  out_word_t out_word_o;

  // APB
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  in_word_t  pending_points[$];
  out_word_t expected_results[$];

  logic [COUNT_WIDTH-1:0] limit_shadow = MAX_ITER_RESET;

  int points_queued = 0;
  int results_seen  = 0;
  int errors        = 0;

  // percent of cycles each side sits idle
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // receiver long stall: requested once, counted in the monitor
  logic long_hold_req = 1'b0;
  int   hold_count    = 0;

  mandelbrot_escape_time dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_word_o  (out_word_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Clamp a wide sum back into the coordinate range.
  function automatic logic signed [COORD_WIDTH-1:0] clamp_coord(
      input logic signed [SUM_WIDTH-1:0] v);
    logic signed [COORD_WIDTH-1:0] top_c;
    logic signed [COORD_WIDTH-1:0] bot_c;
    logic signed [SUM_WIDTH-1:0]   top_w;
    logic signed [SUM_WIDTH-1:0]   bot_w;
    top_c = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    bot_c = ~top_c;
    top_w = SUM_WIDTH'(top_c);
    bot_w = SUM_WIDTH'(bot_c);
    if (v > top_w) return top_c;
    if (v < bot_w) return bot_c;
    return v[COORD_WIDTH-1:0];
  endfunction

  // Escape-time count for one point at the current limit.
  // Products are exact at double width; only |z|^2 strictly above 4 escapes.
  function automatic out_word_t predict_escape(input in_word_t w,
                                               input logic [COUNT_WIDTH-1:0] limit);
    logic signed [SUM_WIDTH-1:0] xw, yw, crw, ciw;
    logic signed [SUM_WIDTH-1:0] xx, yy, xy, mag, four_q, re, im;
    logic signed [COORD_WIDTH-1:0] x, y;
    logic [COUNT_WIDTH-1:0] left;
    logic done;
    out_word_t r;
    four_q = SUM_WIDTH'(1);
    four_q = four_q << (2 * FRAC_BITS + 2);
    crw  = SUM_WIDTH'(w.c_real);
    ciw  = SUM_WIDTH'(w.c_imag);
    x    = w.c_real;
    y    = w.c_imag;
    left = limit;
    done = 1'b0;
    r    = '0;
    while (!done) begin
      xw  = SUM_WIDTH'(x);
      yw  = SUM_WIDTH'(y);
      xx  = xw * xw;
      yy  = yw * yw;
      xy  = xw * yw;
      mag = xx + yy;
      if (mag > four_q) begin
        r.escape_count = left;
        r.in_set       = 1'b0;
        done           = 1'b1;
      end else if (left == '0) begin
        r.escape_count = '0;
        r.in_set       = 1'b1;
        done           = 1'b1;
      end else begin
        left = left - COUNT_WIDTH'(1);
        re   = ((xx - yy) >>> FRAC_BITS) + crw;
        im   = ((xy + xy) >>> FRAC_BITS) + ciw;
        x    = clamp_coord(re);
        y    = clamp_coord(im);
      end
    end
    return r;
  endfunction

  // center +/- half, uniform
  function automatic int span_coord(input int center, input int half);
    int off;
    off = int'($urandom_range(0, 2 * half)) - half;
    return center + off;
  endfunction

  // Point mix: mostly near the set where orbits run long, some noise
  // over the full word, some points a few LSBs off the exact boundaries.
  function automatic in_word_t gen_point();
    in_word_t p;
    int sel;
    int re_base[6];
    int im_base[5];
    re_base = '{TWO, -TWO, ONE / 4, -ONE, 0, -(3 * ONE / 4)};
    im_base = '{0, TWO, -TWO, ONE, ONE / 10};
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      p.c_real = $urandom;
      p.c_imag = $urandom;
    end else if (sel < 30) begin
      p.c_real = span_coord(0, TWO);
      p.c_imag = span_coord(0, TWO);
    end else if (sel < 80) begin
      p.c_real = span_coord(-(3 * ONE / 4), 5 * ONE / 4);
      p.c_imag = span_coord(0, 5 * ONE / 4);
    end else if (sel < 90) begin
      // main cardioid interior, mostly never escapes
      p.c_real = span_coord(-(ONE / 8), 3 * ONE / 8);
      p.c_imag = span_coord(0, ONE / 2);
    end else begin
      p.c_real = span_coord(re_base[$urandom_range(0, 5)], 3);
      p.c_imag = span_coord(im_base[$urandom_range(0, 4)], 3);
    end
    return p;
  endfunction

  task automatic queue_xy(input int re, input int im);
    in_word_t p;
    p.c_real = re;
    p.c_imag = im;
    pending_points.push_back(p);
    points_queued++;
  endtask

  task automatic queue_random(input int n);
    in_word_t p;
    for (int k = 0; k < n; k++) begin
      p = gen_point();
      queue_xy(p.c_real, p.c_imag);
    end
  endtask

  // Block until every queued point has produced its result.
  task automatic drain_block();
    while (results_seen < points_queued) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write of the iteration limit: setup cycle, then access cycle,
  // then a readback of the register.
  task automatic write_max_iter(input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * REG_MAX_ITER);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (pready !== 1'b1) begin
      $error("pready expected %0d got %0d", 1'b1, pready);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    limit_shadow = value[COUNT_WIDTH-1:0];
    @(posedge clk_i);
    if (prdata !== 32'(limit_shadow)) begin
      $error("max_iterations expected %0d got %0d", limit_shadow, prdata);
      errors++;
    end
  endtask

  // Driver: presents pending points, predicts each one as it is taken.
  always @(posedge clk_i) begin
    logic fire;
    fire = in_valid && in_ready_o;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_word  <= '0;
    end else begin
      if (fire) expected_results.push_back(predict_escape(in_word, limit_shadow));
      if (!in_valid || fire) begin
        if (pending_points.size() != 0 &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          in_word  <= pending_points.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each taken result word against the oldest prediction.
  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected: count %0d in_set %0d",
                 out_word_o.escape_count, out_word_o.in_set);
          errors++;
        end else begin
          exp_w = expected_results.pop_front();
          if (out_word_o.escape_count !== exp_w.escape_count) begin
            $error("escape_count expected %0d got %0d",
                   exp_w.escape_count, out_word_o.escape_count);
            errors++;
          end
          if (out_word_o.in_set !== exp_w.in_set) begin
            $error("in_set expected %0d got %0d", exp_w.in_set, out_word_o.in_set);
            errors++;
          end
        end
      end
      if (long_hold_req && hold_count < LONG_HOLD) begin
        out_ready  <= 1'b0;
        hold_count <= hold_count + 1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Sequence of phases.
  initial begin
    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;

    // sender idles often, receiver more so
    send_idle_pct = 21;
    recv_idle_pct = 51;

    // directed points at the reset limit
    queue_xy(0, 0);                                    // in set
    queue_xy(32'sh8000_0000, 32'sh8000_0000);          // both minimum
    queue_xy(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);          // both maximum
    queue_xy(32'sh8000_0000, 32'sh7FFF_FFFF);
    queue_xy(32'sh7FFF_FFFF, 0);
    queue_xy(TWO, 0);            // |z|^2 == 4 exactly, no escape on first test
    queue_xy(-TWO, 0);           // stays on |z| == 2, never escapes
    queue_xy(0, TWO);
    queue_xy(0, -TWO);
    queue_xy(TWO + 1, 0);        // one LSB past the radius
    queue_xy(-TWO - 1, 0);
    queue_xy(ONE / 4, 0);        // cusp, slow convergence
    queue_xy(ONE / 4 + (ONE >> 10), 0);                // just outside the cusp
    queue_xy(-ONE, 0);           // period two
    queue_xy(0, ONE);            // preperiodic orbit
    queue_xy(-(3 * ONE / 4), ONE / 10);
    queue_xy(ONE, ONE);
    drain_block();

    // limit zero: single escape test, count always 0
    write_max_iter(32'd0);
    queue_xy(0, 0);
    queue_xy(32'sh8000_0000, 0);
    queue_xy(TWO, 0);
    queue_random(40);
    drain_block();

    // upper bits of the write are dropped: limit 5
    write_max_iter(32'hFFFF_FC05);
    queue_xy(-TWO, 0);
    queue_xy(ONE / 4 + (ONE >> 4), 0);
    queue_random(60);
    drain_block();

    // largest limit, few points since in-set ones run every round up to the limit
    write_max_iter(32'hFFFF_FFFF);
    queue_random(16);
    drain_block();

    // receiver idles less than sender now
    send_idle_pct = 51;
    recv_idle_pct = 21;
    for (int b = 0; b < 4; b++) begin
      write_max_iter($urandom_range(1, 64));
      queue_random(40);
      drain_block();
    end

    // no idling; long receiver stall fills the block
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_max_iter(32'd50);
    long_hold_req = 1'b1;
    queue_random(60);
    // sender pauses here until every result is back
    drain_block();
    queue_random(60);
    drain_block();

    for (int b = 0; b < 4; b++) begin
      write_max_iter($urandom_range(1, 64));
      queue_random(40);
      drain_block();
    end

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb_mandelbrot_escape_time: PASS");
    end else begin
      $display("tb_mandelbrot_escape_time: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(10_000_000);
    $display("tb_mandelbrot_escape_time: FAIL");
    $finish;
  end

endmodule
